### rtl/core/pfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared widths, register indexes, job and config types and the 2^-x table
// for the pitch-fall envelope.
// ----------------------------------------------------------------------------
package pfe_pkg;

    localparam int FREQ_W          = 24;
    localparam int STEP_W          = 28;
    localparam int HOLD_W          = 20;
    localparam int ACC_W           = 32;
    localparam int ACC_FRAC_BITS   = 28;
    localparam int ACC_INT_W       = ACC_W - ACC_FRAC_BITS;
    localparam logic [ACC_W:0] ACC_MAX = (ACC_W+1)'(64'd8 << ACC_FRAC_BITS);

    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 28;
    localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_FRAMES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_FREQ  = 2'd2;

    localparam logic [STEP_W-1:0] OCTAVE_STEP_RST = 28'd3044;
    localparam logic [HOLD_W-1:0] HOLD_FRAMES_RST = 20'd0;
    localparam logic [FREQ_W-1:0] FLOOR_FREQ_RST  = 24'd5120;

    // Fraction table: 2^-(i / 2^FRAC_TABLE_BITS) in Q1.30
    localparam int FRAC_TABLE_BITS = 6;
    localparam int TAB_N           = 1 << FRAC_TABLE_BITS;
    localparam int TAB_SIZE        = TAB_N + 1;
    localparam int Q_BITS          = 30;
    localparam int TAB_W           = Q_BITS + 1;
    localparam int REM_BITS        = ACC_FRAC_BITS - FRAC_TABLE_BITS;
    localparam int PROD1_W         = TAB_W + REM_BITS;
    localparam int PROD2_W         = FREQ_W + TAB_W;
    localparam int SHIFT_W         = 6;

    localparam int QUEUE_DEPTH     = 2;

    typedef logic [63:0] t_root [10];
    // 2^-(2^-k) in Q0.30 for k = 1..10
    localparam t_root ROOT_CONSTS = '{
        64'd759250125,  64'd902905651,  64'd984625594,  64'd1028218693,
        64'd1050733751, 64'd1062175491, 64'd1067942999, 64'd1070838486,
        64'd1072289173, 64'd1073015252
    };

    typedef logic [TAB_W-1:0] t_tab [TAB_SIZE];

    function automatic t_tab build_tab();
        t_tab        tab;
        logic [63:0] v;
        for (int i = 0; i < TAB_SIZE; i++) begin
            if (i == TAB_N) begin
                v = 64'd1 << (Q_BITS - 1);
            end else begin
                v = 64'd1 << Q_BITS;
                for (int p = 0; p < FRAC_TABLE_BITS; p++) begin
                    if (((i >> p) & 1) != 0) begin
                        v = (v * ROOT_CONSTS[FRAC_TABLE_BITS - p - 1]
                             + (64'd1 << (Q_BITS - 1))) >> Q_BITS;
                    end
                end
            end
            tab[i] = v[TAB_W-1:0];
        end
        return tab;
    endfunction

    localparam t_tab FRAC_TAB = build_tab();

    typedef struct packed {
        logic [STEP_W-1:0] octave_step;
        logic [HOLD_W-1:0] hold_frames;
        logic [FREQ_W-1:0] floor_freq;
    } t_cfg_regs;

    // One classified frame handed from front to back
    typedef struct packed {
        logic              holding;
        logic [FREQ_W-1:0] freq;
        logic [ACC_W-1:0]  acc;
    } t_job;

endpackage
`default_nettype wire

### rtl/core/pfe_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfe interfaces
// Valid/ready channels for input frames, results and register writes.
// ----------------------------------------------------------------------------
interface pfe_in_if;
    logic                      valid;
    logic                      ready;
    logic                      operation;
    logic [pfe_pkg::FREQ_W-1:0] freq_in;
    modport source (output valid, output operation, output freq_in, input ready);
    modport sink   (input valid, input operation, input freq_in, output ready);
endinterface

interface pfe_out_if;
    logic                      valid;
    logic                      ready;
    logic [pfe_pkg::FREQ_W-1:0] freq_out;
    logic                      holding;
    modport source (output valid, output freq_out, output holding, input ready);
    modport sink   (input valid, input freq_out, input holding, output ready);
endinterface

interface pfe_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pfe_pkg::CFG_IDX_W-1:0]  index;
    logic [pfe_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/pfe_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfe_front
// Accepts frames, keeps hold counter and octave accumulator, classifies each
// frame as restart, hold or fall and queues hold/fall jobs for the back end.
// ----------------------------------------------------------------------------
module pfe_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    pfe_in_if.sink              i_in,
    input  pfe_pkg::t_cfg_regs  i_cfg_regs,
    input  wire                 i_queue_full,
    output logic                o_push,
    output pfe_pkg::t_job       o_job
);
    import pfe_pkg::*;

    logic [HOLD_W-1:0] r_hold_count, n_hold_count;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic              accept;
    logic [ACC_W:0]    acc_sum;

    assign i_in.ready = !i_queue_full;
    assign accept     = i_in.valid && !i_queue_full;
    assign acc_sum    = {1'b0, r_acc} + (ACC_W+1)'(i_cfg_regs.octave_step);

    always_comb begin
        n_hold_count  = r_hold_count;
        n_acc         = r_acc;
        o_push        = 1'b0;
        o_job.holding = 1'b0;
        o_job.freq    = i_in.freq_in;
        o_job.acc     = r_acc;
        if (accept) begin
            if (i_in.operation) begin
                n_hold_count = '0;
                n_acc        = '0;
            end else if (r_hold_count < i_cfg_regs.hold_frames) begin
                n_hold_count  = r_hold_count + HOLD_W'(1);
                o_push        = 1'b1;
                o_job.holding = 1'b1;
            end else begin
                // clamp at eight octaves
                n_acc     = (acc_sum > ACC_MAX) ? ACC_MAX[ACC_W-1:0] : acc_sum[ACC_W-1:0];
                o_push    = 1'b1;
                o_job.acc = n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_count <= '0;
            r_acc        <= '0;
        end else begin
            r_hold_count <= n_hold_count;
            r_acc        <= n_acc;
        end
    end

endmodule
`default_nettype wire

### rtl/core/pfe_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfe_queue
// Small FIFO of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module pfe_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  pfe_pkg::t_job   i_push_job,
    input  wire             i_pop,
    output logic            o_full,
    output logic            o_empty,
    output pfe_pkg::t_job   o_head
);
    import pfe_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

### rtl/core/pfe_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfe_back
// Sequencer that lowers a frequency by 2^-acc (hold jobs skip to output): table
// lookup, interpolation multiply, frequency multiply, rounding shift and floor,
// then an output register toward the result channel.
// ----------------------------------------------------------------------------
module pfe_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  pfe_pkg::t_cfg_regs  i_cfg_regs,
    input  wire                 i_queue_empty,
    input  pfe_pkg::t_job       i_head,
    output logic                o_pop,
    pfe_out_if.source           o_out
);
    import pfe_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_TAB    = 3'd1;
    localparam logic [2:0] S_MUL1   = 3'd2;
    localparam logic [2:0] S_INTERP = 3'd3;
    localparam logic [2:0] S_MUL2   = 3'd4;
    localparam logic [2:0] S_ROUND  = 3'd5;
    localparam logic [2:0] S_FLOOR  = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    logic [2:0]                 r_state, n_state;
    logic                       r_holding, n_holding;
    logic [FREQ_W-1:0]          r_freq, n_freq;
    logic [ACC_W-1:0]           r_acc, n_acc;
    logic [TAB_W-1:0]           r_a, n_a;
    logic [TAB_W-1:0]           r_b, n_b;
    logic [REM_BITS-1:0]        r_rem, n_rem;
    logic [ACC_INT_W-1:0]       r_ip, n_ip;
    logic [PROD1_W-1:0]         r_prod1, n_prod1;
    logic [TAB_W-1:0]           r_m, n_m;
    logic [PROD2_W-1:0]         r_prod2, n_prod2;
    logic [FREQ_W-1:0]          r_res, n_res;
    logic                       r_out_valid, n_out_valid;
    logic [FREQ_W-1:0]          r_out_freq, n_out_freq;
    logic                       r_out_hold, n_out_hold;

    logic [FRAC_TABLE_BITS-1:0] idx;
    logic [FRAC_TABLE_BITS:0]   idx_next;
    logic [PROD1_W:0]           interp_sum;
    logic [SHIFT_W-1:0]         shift;
    logic [PROD2_W:0]           round_sum;
    logic                       load_out;

    assign idx        = r_acc[ACC_FRAC_BITS-1 -: FRAC_TABLE_BITS];
    assign idx_next   = {1'b0, idx} + (FRAC_TABLE_BITS+1)'(1);
    assign interp_sum = {1'b0, r_prod1} + ((PROD1_W+1)'(1) << (REM_BITS - 1));
    assign shift      = SHIFT_W'(Q_BITS) + SHIFT_W'(r_ip);
    assign round_sum  = {1'b0, r_prod2} + ((PROD2_W+1)'(1) << (shift - SHIFT_W'(1)));
    assign load_out   = (r_state == S_OUT) && (!r_out_valid || o_out.ready);
    assign o_pop      = (r_state == S_IDLE) && !i_queue_empty;

    assign o_out.valid    = r_out_valid;
    assign o_out.freq_out = r_out_freq;
    assign o_out.holding  = r_out_hold;

    always_comb begin
        n_state     = r_state;
        n_holding   = r_holding;
        n_freq      = r_freq;
        n_acc       = r_acc;
        n_a         = r_a;
        n_b         = r_b;
        n_rem       = r_rem;
        n_ip        = r_ip;
        n_prod1     = r_prod1;
        n_m         = r_m;
        n_prod2     = r_prod2;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_freq  = r_out_freq;
        n_out_hold  = r_out_hold;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (!i_queue_empty) begin
                    n_holding = i_head.holding;
                    n_freq    = i_head.freq;
                    n_acc     = i_head.acc;
                    n_res     = i_head.freq;
                    // hold frames pass straight through, no floor
                    n_state   = i_head.holding ? S_OUT : S_TAB;
                end
            end
            S_TAB: begin
                n_a     = FRAC_TAB[{1'b0, idx}];
                n_b     = FRAC_TAB[idx_next];
                n_rem   = r_acc[REM_BITS-1:0];
                n_ip    = r_acc[ACC_W-1 -: ACC_INT_W];
                n_state = S_MUL1;
            end
            S_MUL1: begin
                n_prod1 = PROD1_W'(r_a - r_b) * PROD1_W'(r_rem);
                n_state = S_INTERP;
            end
            S_INTERP: begin
                n_m     = r_a - TAB_W'(interp_sum >> REM_BITS);
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_prod2 = PROD2_W'(r_freq) * PROD2_W'(r_m);
                n_state = S_ROUND;
            end
            S_ROUND: begin
                n_res   = FREQ_W'(round_sum >> shift);
                n_state = S_FLOOR;
            end
            S_FLOOR: begin
                if (r_res < i_cfg_regs.floor_freq) begin
                    n_res = i_cfg_regs.floor_freq;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (load_out) begin
                    n_out_valid = 1'b1;
                    n_out_freq  = r_res;
                    n_out_hold  = r_holding;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_holding  <= n_holding;
        r_freq     <= n_freq;
        r_acc      <= n_acc;
        r_a        <= n_a;
        r_b        <= n_b;
        r_rem      <= n_rem;
        r_ip       <= n_ip;
        r_prod1    <= n_prod1;
        r_m        <= n_m;
        r_prod2    <= n_prod2;
        r_res      <= n_res;
        r_out_freq <= n_out_freq;
        r_out_hold <= n_out_hold;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

### rtl/core/pitch_fall_envelope_top.sv
`timescale 1ns / 1ps
`default_nettype none
// A falling frame's result goes through the back-end sequencer (lookup, two multiplies,
// interpolate, round, floor, output); a hold frame's goes straight to output. A new job
// is taken only after the last result is loaded into the output register, which waits
// for ready. Restart frames give no result. Two queued jobs let the input run ahead.
// Reset (synchronous, active low) clears hold count, accumulator, queue and output valid
// and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// pitch_fall_envelope_top
// Exponential pitch-fall envelope: hold, then per-frame octave sweep with
// floor, behind valid/ready channels and a register write channel.
// ----------------------------------------------------------------------------
module pitch_fall_envelope_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    pfe_in_if.sink      i_in,
    pfe_out_if.source   o_out,
    pfe_cfg_if.sink     i_cfg
);
    import pfe_pkg::*;

    t_cfg_regs r_cfg;
    logic      push;
    logic      pop;
    logic      queue_full;
    logic      queue_empty;
    t_job      push_job;
    t_job      head_job;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.octave_step <= OCTAVE_STEP_RST;
            r_cfg.hold_frames <= HOLD_FRAMES_RST;
            r_cfg.floor_freq  <= FLOOR_FREQ_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_OCTAVE_STEP: r_cfg.octave_step <= i_cfg.data[STEP_W-1:0];
                REG_HOLD_FRAMES: r_cfg.hold_frames <= i_cfg.data[HOLD_W-1:0];
                REG_FLOOR_FREQ:  r_cfg.floor_freq  <= i_cfg.data[FREQ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    pfe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg_regs   (r_cfg),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_job        (push_job)
    );

    pfe_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .i_pop      (pop),
        .o_full     (queue_full),
        .o_empty    (queue_empty),
        .o_head     (head_job)
    );

    pfe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_regs    (r_cfg),
        .i_queue_empty (queue_empty),
        .i_head        (head_job),
        .o_pop         (pop),
        .o_out         (o_out)
    );

endmodule
`default_nettype wire
